// ===== rtl/tfra_pkg.sv =====
// Shared types, constants and a helper function of the reassignment accumulator.
package tfra_pkg;

    // Default matrix size
    localparam int TIME_MAX_DEF = 64;
    localparam int FREQ_MAX_DEF = 64;

    // Field widths
    localparam int BIN_W   = 6;
    localparam int SHIFT_W = 16;
    localparam int VAL_W   = 24;
    localparam int SUM_W   = 40;
    localparam int SIZE_W  = 7;
    localparam int POS_W   = 17;
    localparam int MAG_W   = 12;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 2 * SUM_W;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SIZE_W;
    localparam logic [CFG_INDEX_W-1:0] REG_N_TIME     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_N_FREQ     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLEX_EN = 2'd2;

    localparam logic [SIZE_W-1:0] N_TIME_RST     = 7'd64;
    localparam logic [SIZE_W-1:0] N_FREQ_RST     = 7'd64;
    localparam logic              COMPLEX_EN_RST = 1'b1;

    // Commands
    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Remainder unit: one quotient bit per step
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES          = MAG_W / DIV_STEPS_PER_STAGE;

    localparam int QUEUE_DEPTH = 2;

    // Item as it travels through the front pipeline
    typedef struct packed {
        logic                    cmd;
        logic                    in_range;
        logic [BIN_W-1:0]        t;
        logic [BIN_W-1:0]        f;
        logic [SIZE_W-1:0]       tt;
        logic                    fneg;
        logic [MAG_W-1:0]        mag;
        logic [SIZE_W-1:0]       rem;
        logic signed [VAL_W-1:0] real_value;
        logic signed [VAL_W-1:0] imag_value;
    } pipe_t;

    // Operation handed from the front to the back
    typedef struct packed {
        logic                    cmd;
        logic                    in_range;
        logic signed [VAL_W-1:0] real_value;
        logic signed [VAL_W-1:0] imag_value;
    } op_t;

    function automatic int addr_width(input int cells);
        addr_width = (cells > 1) ? $clog2(cells) : 1;
    endfunction

endpackage

// ===== rtl/tfr_pixel_reassign_accumulate_core.sv =====
// Top level of the reassigned time-frequency pixel accumulator.
// A read item's result reaches m_tvalid via the input register, front stages, queue, store
// read and result register. The sequencer pops no item until its read-modify-write is done.
// Reset: synchronous, active low; afterwards a clearing pass zeroes both stores, during which
// s_tready stays low. Configuration writes are taken always.
module tfr_pixel_reassign_accumulate_core
    import tfra_pkg::*;
#(
    parameter int TIME_MAX = TIME_MAX_DEF,
    parameter int FREQ_MAX = FREQ_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: pixel_time[5:0], pixel_freq[11:6], shift_time[27:12], shift_freq[43:28],
    //          real_value[67:44], imag_value[91:68], zero[95:92]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,   // command[0]
    // m_tdata: real_sum[39:0], imag_sum[79:40]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CELLS  = TIME_MAX * FREQ_MAX;
    localparam int ADDR_W = addr_width(CELLS);
    localparam int QW     = $bits(op_t) + ADDR_W;

    logic [SIZE_W-1:0] n_time_reg;
    logic [SIZE_W-1:0] n_freq_reg;
    logic              complex_en_reg;

    logic              clr_busy;
    logic              q_push, q_pop, q_full, q_empty;
    op_t               f_op, b_op;
    logic [ADDR_W-1:0] f_addr, b_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_time_reg     <= N_TIME_RST;
            n_freq_reg     <= N_FREQ_RST;
            complex_en_reg <= COMPLEX_EN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_N_TIME:     n_time_reg     <= cfg_wdata;
                REG_N_FREQ:     n_freq_reg     <= cfg_wdata;
                REG_COMPLEX_EN: complex_en_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    tfra_front #(
        .TIME_MAX (TIME_MAX),
        .FREQ_MAX (FREQ_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .n_time   (n_time_reg),
        .n_freq   (n_freq_reg),
        .clr_busy (clr_busy),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (f_op),
        .q_addr   (f_addr)
    );

    tfra_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_op, f_addr}),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   ({b_op, b_addr}),
        .empty   (q_empty)
    );

    tfra_back #(
        .CELLS (CELLS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .complex_en (complex_en_reg),
        .q_empty    (q_empty),
        .q_op       (b_op),
        .q_addr     (b_addr),
        .q_pop      (q_pop),
        .clr_busy   (clr_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // No item may enter while the stores are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn) clr_busy |-> !s_tready)
        else $error("item accepted during clearing pass");

    // The front must never push into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("queue overflow");

    // The sequencer must never pop an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("queue underflow");

    // A pop always starts a store access in ST_RMW, so no pop follows directly.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |=> !q_pop)
        else $error("back-to-back store access");

endmodule

// ===== rtl/tfra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tfra_ram
    import tfra_pkg::*;
#(
    parameter int WIDTH = SUM_W,
    parameter int DEPTH = TIME_MAX_DEF * FREQ_MAX_DEF,
    localparam int AW = addr_width(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tfra_queue.sv =====
// Short register queue between the front pipeline and the store sequencer.
module tfra_queue
    import tfra_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full  = (count_reg == (PW + 1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/tfra_front.sv =====
// Front pipeline: accepts items, rounds and clamps targets, wraps frequency, forms addresses.
module tfra_front
    import tfra_pkg::*;
#(
    parameter int TIME_MAX = TIME_MAX_DEF,
    parameter int FREQ_MAX = FREQ_MAX_DEF,
    localparam int ADDR_W = addr_width(TIME_MAX * FREQ_MAX)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic [SIZE_W-1:0]    n_time,
    input  logic [SIZE_W-1:0]    n_freq,
    input  logic                 clr_busy,
    input  logic                 q_full,
    output logic                 q_push,
    output op_t                  q_op,
    output logic [ADDR_W-1:0]    q_addr
);

    localparam int NSTAGE = DIV_STAGES + 2;
    localparam logic [SIZE_W-1:0] TIME_CAP = SIZE_W'((TIME_MAX < 127) ? TIME_MAX : 127);
    localparam logic [SIZE_W-1:0] FREQ_CAP = SIZE_W'((FREQ_MAX < 127) ? FREQ_MAX : 127);

    logic [NSTAGE-1:0] vld_reg;

    logic                      s0_cmd_reg;
    logic [BIN_W-1:0]          s0_t_reg;
    logic [BIN_W-1:0]          s0_f_reg;
    logic signed [SHIFT_W-1:0] s0_st_reg;
    logic signed [SHIFT_W-1:0] s0_sf_reg;
    logic signed [VAL_W-1:0]   s0_rv_reg;
    logic signed [VAL_W-1:0]   s0_iv_reg;

    pipe_t pipe_reg [DIV_STAGES+1];
    pipe_t pipe_next [DIV_STAGES+1];

    logic [SIZE_W-1:0]       nt_eff, nf_eff;
    logic signed [POS_W-1:0] vt, vf;
    logic [MAG_W-1:0]        rt;
    logic                    adv, keep;
    pipe_t                   last;
    logic [SIZE_W-1:0]       tf, row, col;

    // Rounds a Q.4 position to its integer magnitude, halves away from zero.
    function automatic logic [MAG_W-1:0] round_mag(input logic signed [POS_W-1:0] v);
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] sum;
        mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
        sum = mag + POS_W'(8);
        return sum[MAG_W+3:4];
    endfunction

    // A group of restoring remainder steps, one dividend bit per step.
    function automatic pipe_t rem_steps(input pipe_t p, input logic [SIZE_W-1:0] nf);
        pipe_t           r;
        logic [SIZE_W:0] trial;
        r = p;
        for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            trial = {r.rem, r.mag[MAG_W-1]};
            r.mag = {r.mag[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, nf}) begin
                r.rem = SIZE_W'(trial - {1'b0, nf});
            end else begin
                r.rem = trial[SIZE_W-1:0];
            end
        end
        return r;
    endfunction

    assign nt_eff = (n_time == '0) ? SIZE_W'(1) : ((n_time > TIME_CAP) ? TIME_CAP : n_time);
    assign nf_eff = (n_freq == '0) ? SIZE_W'(1) : ((n_freq > FREQ_CAP) ? FREQ_CAP : n_freq);

    always_comb begin
        vt = POS_W'($signed({1'b0, s0_t_reg, 4'b0000})) + POS_W'(s0_st_reg);
        vf = POS_W'($signed({1'b0, s0_f_reg, 4'b0000})) + POS_W'(s0_sf_reg);
        rt = round_mag(vt);

        pipe_next[0].cmd        = s0_cmd_reg;
        pipe_next[0].in_range   = ({1'b0, s0_t_reg} < nt_eff) && ({1'b0, s0_f_reg} < nf_eff);
        pipe_next[0].t          = s0_t_reg;
        pipe_next[0].f          = s0_f_reg;
        pipe_next[0].fneg       = vf[POS_W-1];
        pipe_next[0].mag        = round_mag(vf);
        pipe_next[0].rem        = '0;
        pipe_next[0].real_value = s0_rv_reg;
        pipe_next[0].imag_value = s0_iv_reg;
        // Negative time targets clamp to the first row, too large ones to the last.
        if (vt[POS_W-1]) begin
            pipe_next[0].tt = '0;
        end else if (rt > MAG_W'(nt_eff - 1'b1)) begin
            pipe_next[0].tt = nt_eff - 1'b1;
        end else begin
            pipe_next[0].tt = rt[SIZE_W-1:0];
        end

        for (int k = 0; k < DIV_STAGES; k++) begin
            pipe_next[k+1] = rem_steps(pipe_reg[k], nf_eff);
        end
    end

    assign last     = pipe_reg[DIV_STAGES];
    assign keep     = (last.cmd == CMD_READ) || last.in_range;
    assign adv      = !vld_reg[NSTAGE-1] || !keep || !q_full;
    assign s_tready = adv && !clr_busy;
    assign q_push   = vld_reg[NSTAGE-1] && keep && !q_full;

    // A negative frequency with a non-zero remainder wraps up from n_freq.
    assign tf  = (last.fneg && last.rem != '0) ? nf_eff - last.rem : last.rem;
    assign row = (last.cmd == CMD_READ) ? {1'b0, last.t} : last.tt;
    assign col = (last.cmd == CMD_READ) ? {1'b0, last.f} : tf;

    assign q_addr = ADDR_W'(int'(row) * FREQ_MAX + int'(col));

    assign q_op.cmd        = last.cmd;
    assign q_op.in_range   = last.in_range;
    assign q_op.real_value = last.real_value;
    assign q_op.imag_value = last.imag_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_tvalid && s_tready};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_cmd_reg <= s_tuser[0];
            s0_t_reg   <= s_tdata[5:0];
            s0_f_reg   <= s_tdata[11:6];
            s0_st_reg  <= s_tdata[27:12];
            s0_sf_reg  <= s_tdata[43:28];
            s0_rv_reg  <= s_tdata[67:44];
            s0_iv_reg  <= s_tdata[91:68];
            for (int k = 0; k <= DIV_STAGES; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

endmodule

// ===== rtl/tfra_back.sv =====
// Store sequencer: clearing pass, read-modify-write of the cell stores and result register.
module tfra_back
    import tfra_pkg::*;
#(
    parameter int CELLS = TIME_MAX_DEF * FREQ_MAX_DEF,
    localparam int ADDR_W = addr_width(CELLS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 complex_en,
    input  logic                 q_empty,
    input  op_t                  q_op,
    input  logic [ADDR_W-1:0]    q_addr,
    output logic                 q_pop,
    output logic                 clr_busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RMW  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    op_t                  op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic              out_free;
    logic              re_we, im_we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  re_wdata, im_wdata, re_rdata, im_rdata;

    assign out_free = !m_valid_reg || m_tready;
    assign clr_busy = (state_reg == ST_CLR);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        q_pop         = 1'b0;
        re_we         = 1'b0;
        im_we         = 1'b0;
        waddr         = addr_reg;
        re_wdata      = '0;
        im_wdata      = '0;
        unique case (state_reg)
            ST_CLR: begin
                re_we         = 1'b1;
                im_we         = 1'b1;
                waddr         = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // A read waits until the result register will be free.
                if (!q_empty && (q_op.cmd == CMD_ACC || out_free)) begin
                    q_pop      = 1'b1;
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                state_next = ST_IDLE;
                if (op_reg.cmd == CMD_ACC) begin
                    re_we    = 1'b1;
                    im_we    = complex_en;
                    re_wdata = re_rdata + SUM_W'(op_reg.real_value);
                    im_wdata = im_rdata + SUM_W'(op_reg.imag_value);
                end else begin
                    re_we        = op_reg.in_range;
                    im_we        = op_reg.in_range;
                    m_valid_next = 1'b1;
                    m_data_next  = op_reg.in_range ? {im_rdata, re_rdata} : '0;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (q_pop) begin
            op_reg   <= q_op;
            addr_reg <= q_addr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    tfra_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CELLS)
    ) u_real_store (
        .aclk  (aclk),
        .we    (re_we),
        .waddr (waddr),
        .wdata (re_wdata),
        .re    (q_pop),
        .raddr (q_addr),
        .rdata (re_rdata)
    );

    tfra_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CELLS)
    ) u_imag_store (
        .aclk  (aclk),
        .we    (im_we),
        .waddr (waddr),
        .wdata (im_wdata),
        .re    (q_pop),
        .raddr (q_addr),
        .rdata (im_rdata)
    );

endmodule
